>>> rtl/thdc_pkg.sv
// ----------------------------------------------------------------------------
// thdc_pkg
// Types, constants and codes shared by the track to hit distance cut.
// ----------------------------------------------------------------------------
package thdc_pkg;

	localparam int COORD_BITS   = 24;
	localparam int STN_W        = 3;
	localparam int SCORE_BITS   = 23;
	localparam int MAX_HITS_DEF = 256;
	localparam int NUM_STN_DEF  = 5;
	localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TRACK = 2'd1,
		OP_END   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_SCORED   = 2'd0,
		ST_NO_TRACK = 2'd1,
		ST_NO_PLANE = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	localparam logic CFG_THRESH = 1'b0;
	localparam logic CFG_MODE   = 1'b1;

	typedef enum logic [1:0] {
		DS_STATION = 2'd0,
		DS_AVG_V   = 2'd1,
		DS_AVG_H   = 2'd2
	} div_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_DSEL,
		S_DWAIT,
		S_AVGV,
		S_AVGVW,
		S_AVGHW,
		S_MERGE
	} state_t;

	typedef struct packed {
		op_t                          op;
		logic                         hit_vertical;
		logic [STN_W-1:0]             hit_station;
		logic                         hit_usable;
		logic signed [COORD_BITS-1:0] coord_0;
		logic signed [COORD_BITS-1:0] coord_1;
		logic signed [COORD_BITS-1:0] coord_2;
		logic signed [COORD_BITS-1:0] coord_3;
		logic signed [COORD_BITS-1:0] coord_4;
		logic signed [COORD_BITS-1:0] coord_5;
	} item_t;

	typedef struct packed {
		logic [SCORE_BITS-1:0] event_score;
		logic                  passed;
		status_t               status;
	} result_t;

	typedef struct packed {
		logic             hit_wr;
		logic             trk_start;
		logic             rd_en;
		logic             div_go;
		div_src_t         div_src;
		logic             sel_h;
		logic [STN_W-1:0] sel_idx;
		logic             set_fail;
		logic             merge;
		logic             end_evt;
	} cmd_t;

	typedef struct packed {
		logic event_failed;
		logic pipe_busy;
		logic div_done;
		logic seen_sel;
		logic no_plane;
		logic res_pend;
	} sts_t;

endpackage

>>> rtl/track_hit_doca_cut.sv
// ----------------------------------------------------------------------------
// track_hit_doca_cut
// Event cut on track to hit distance of closest approach.
// ----------------------------------------------------------------------------
// Items arrive on the item channel (valid/stall): usable load-hit beats are
// stored, track beats walk the hit store, end-of-event beats post one
// result beat on the result channel (valid/stall) and clear the event.
// Configuration writes (index 0 threshold, 1 mode) use cfg_valid/cfg_ready;
// ready is always high and writes belong to idle periods.
// A track walks the hit store (one hit per cycle through a four stage distance
// pipeline), then runs up to 2*NUM_STATIONS station divisions on the shared
// divider (select, quotient bits, done; a station without hits skips its
// division), then the two average divisions and the merge; a view with no
// station hits instead marks the event failed. The item channel stalls
// until the track is done. An end beat stalls only while an earlier result
// is still stalled.
// The result sits in an output register until taken.
// Reset clears the event, sets the threshold to all ones and the mode to 0;
// the hit store needs no clearing since only counted entries are read.
// ----------------------------------------------------------------------------
module track_hit_doca_cut import thdc_pkg::*; #(
	parameter int MAX_HITS     = MAX_HITS_DEF,
	parameter int NUM_STATIONS = NUM_STN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [SCORE_BITS-1:0] cfg_data
);

	localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int CW = $clog2(MAX_HITS + 1);

	cmd_t          cmd;
	sts_t          sts;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] hit_count;

	assign cfg_ready = 1'b1;

	thdc_ctrl #(
		.MAX_HITS     (MAX_HITS),
		.NUM_STATIONS (NUM_STATIONS),
		.AW           (AW),
		.CW           (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.op           (item.op),
		.result_stall (result_stall),
		.hit_count    (hit_count),
		.sts          (sts),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.rd_addr      (rd_addr)
	);

	thdc_dpath #(
		.MAX_HITS     (MAX_HITS),
		.NUM_STATIONS (NUM_STATIONS),
		.AW           (AW),
		.CW           (CW)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_stall (result_stall),
		.hit_count    (hit_count),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

>>> rtl/thdc_div.sv
// ----------------------------------------------------------------------------
// thdc_div
// Restoring divider, one quotient bit per cycle, saturating at SCORE_MAX.
// ----------------------------------------------------------------------------
module thdc_div import thdc_pkg::*; #(
	parameter int ND = 52,
	parameter int DD = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [ND-1:0]         num,
	input  logic [DD-1:0]         den,
	output logic                  busy,
	output logic                  done,
	output logic [SCORE_BITS-1:0] quot
);

	localparam int LW = (ND > DD + SCORE_BITS) ? ND + 1 : DD + SCORE_BITS + 1;

	logic [LW-1:0]         rem_q;
	logic [LW-1:0]         dsh_q;
	logic [SCORE_BITS-1:0] q_q;
	logic [4:0]            cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [LW-1:0]         num_x;
	logic [LW-1:0]         lim;
	logic                  ge;

	assign num_x = LW'(num);
	assign lim   = LW'(den) << SCORE_BITS;
	assign ge    = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				if (num_x >= lim) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'(SCORE_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= num_x;
			dsh_q <= LW'(den) << (SCORE_BITS - 1);
			q_q   <= (num_x >= lim) ? SCORE_MAX : '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			q_q   <= {q_q[SCORE_BITS-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = q_q;

endmodule

>>> rtl/thdc_dpath.sv
// ----------------------------------------------------------------------------
// thdc_dpath
// Hit store, distance pipeline, station minima, divider, scoring.
// ----------------------------------------------------------------------------
module thdc_dpath import thdc_pkg::*; #(
	parameter int MAX_HITS     = MAX_HITS_DEF,
	parameter int NUM_STATIONS = NUM_STN_DEF,
	parameter int AW           = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1,
	parameter int CW           = $clog2(MAX_HITS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic [AW-1:0]         rd_addr,
	input  item_t                 item,
	input  logic                  cfg_valid,
	input  logic                  cfg_index,
	input  logic [SCORE_BITS-1:0] cfg_data,
	input  logic                  result_stall,
	output logic [CW-1:0]         hit_count,
	output sts_t                  sts,
	output logic                  result_valid,
	output result_t               result
);

	localparam int C    = COORD_BITS;
	localparam int SW   = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
	localparam int EW   = 2 * C + SW + 1;
	localparam int NW   = 2 * C + 3;
	localparam int ND   = NW + 1;
	localparam int DD   = C + 1;
	localparam int CNW  = $clog2(NUM_STATIONS + 1);
	localparam int SUMW = SCORE_BITS + CNW;

	logic [EW-1:0] mem [MAX_HITS];

	logic [SCORE_BITS-1:0] thresh_q;
	logic                  mode_q;
	logic [CW-1:0]         hit_cnt_q;
	logic                  overflow_q;
	logic                  failed_q;
	logic                  tracks_q;
	logic [SCORE_BITS-1:0] run_q;

	logic signed [C-1:0] sx_q, sy_q, sz_q;
	logic signed [C:0]   dx_q, dy_q, dz_q;
	logic [DD-1:0]       den;

	logic [EW-1:0]       rd_s1;
	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic                vert_s2, vert_s3, vert_s4;
	logic [SW-1:0]       sidx_s2, sidx_s3, sidx_s4;
	logic signed [C:0]   a_s2, b_s2, dt_s2;
	logic signed [2*C+1:0] p1_s3, p2_s3;
	logic [NW-1:0]       mag_s4;
	logic signed [NW-1:0] nsum;

	logic [NW-1:0] min_v [NUM_STATIONS];
	logic [NW-1:0] min_h [NUM_STATIONS];
	logic [NUM_STATIONS-1:0] seen_v, seen_h;

	logic [SUMW-1:0]       sum_v_q, sum_h_q;
	logic [CNW-1:0]        cnt_v_q, cnt_h_q;
	logic [SCORE_BITS-1:0] av_q, ah_q;
	div_src_t              src_q;

	logic [SW-1:0]         sel;
	logic [NW-1:0]         min_sel;
	logic [ND-1:0]         div_num;
	logic [DD-1:0]         div_den;
	logic                  div_busy, div_done;
	logic [SCORE_BITS-1:0] div_q;

	logic                  st_ok;
	logic signed [C:0]     zsum, tsum;
	logic [SCORE_BITS-1:0] score;
	logic                  res_valid_q;
	result_t               res_q;
	status_t               st_code;

	assign st_ok = (item.hit_station != '0) &&
		({1'b0, item.hit_station} <= (STN_W + 1)'(NUM_STATIONS));
	assign zsum  = {item.coord_0[C-1], item.coord_0} + {item.coord_1[C-1], item.coord_1};
	assign tsum  = {item.coord_2[C-1], item.coord_2} + {item.coord_3[C-1], item.coord_3};
	assign den   = dz_q[C] ? DD'(-dz_q) : DD'(dz_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= SCORE_MAX;
			mode_q   <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_THRESH)
				thresh_q <= cfg_data;
			else
				mode_q <= cfg_data[0];
		end
	end

	// hit store
	always_ff @(posedge clk) begin
		if (cmd.hit_wr && item.hit_usable && st_ok && hit_cnt_q != CW'(MAX_HITS))
			mem[hit_cnt_q[AW-1:0]] <= {item.hit_vertical, SW'(item.hit_station - 3'd1),
				zsum[C:1], tsum[C:1]};
		if (cmd.rd_en)
			rd_s1 <= mem[rd_addr];
	end

	// event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			overflow_q <= 1'b0;
			failed_q   <= 1'b0;
			tracks_q   <= 1'b0;
			run_q      <= '0;
		end else if (cmd.end_evt) begin
			hit_cnt_q  <= '0;
			overflow_q <= 1'b0;
			failed_q   <= 1'b0;
			tracks_q   <= 1'b0;
			run_q      <= '0;
		end else begin
			if (cmd.hit_wr && item.hit_usable && st_ok) begin
				if (hit_cnt_q == CW'(MAX_HITS))
					overflow_q <= 1'b1;
				else
					hit_cnt_q <= hit_cnt_q + CW'(1);
			end
			if (cmd.set_fail)
				failed_q <= 1'b1;
			if (cmd.merge) begin
				if (!tracks_q || (mode_q ? score > run_q : score < run_q))
					run_q <= score;
				tracks_q <= 1'b1;
			end
		end
	end

	assign score = (av_q > ah_q) ? av_q : ah_q;

	// track latch
	always_ff @(posedge clk) begin
		if (cmd.trk_start) begin
			sx_q <= item.coord_0;
			sy_q <= item.coord_1;
			sz_q <= item.coord_2;
			dx_q <= {item.coord_3[C-1], item.coord_3} - {item.coord_0[C-1], item.coord_0};
			dy_q <= {item.coord_4[C-1], item.coord_4} - {item.coord_1[C-1], item.coord_1};
			dz_q <= {item.coord_5[C-1], item.coord_5} - {item.coord_2[C-1], item.coord_2};
		end
	end

	// distance pipeline: read, differences, products, magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign nsum = NW'(p1_s3) + NW'(p2_s3);

	always_ff @(posedge clk) begin
		vert_s2 <= rd_s1[EW-1];
		sidx_s2 <= rd_s1[2*C+SW-1:2*C];
		a_s2    <= (rd_s1[EW-1] ? {sx_q[C-1], sx_q} : {sy_q[C-1], sy_q})
			- {rd_s1[C-1], rd_s1[C-1:0]};
		b_s2    <= {rd_s1[2*C-1], rd_s1[2*C-1:C]} - {sz_q[C-1], sz_q};
		dt_s2   <= rd_s1[EW-1] ? dx_q : dy_q;
		vert_s3 <= vert_s2;
		sidx_s3 <= sidx_s2;
		p1_s3   <= a_s2 * dz_q;
		p2_s3   <= dt_s2 * b_s2;
		vert_s4 <= vert_s3;
		sidx_s4 <= sidx_s3;
		mag_s4  <= nsum[NW-1] ? NW'(-nsum) : NW'(nsum);
	end

	// per-station minimum of the numerator; the divisor is shared by the track
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_v <= '0;
			seen_h <= '0;
		end else if (cmd.trk_start) begin
			seen_v <= '0;
			seen_h <= '0;
		end else if (valid_s4) begin
			for (int i = 0; i < NUM_STATIONS; i++) begin
				if (sidx_s4 == SW'(i)) begin
					if (vert_s4)
						seen_v[i] <= 1'b1;
					else
						seen_h[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			for (int i = 0; i < NUM_STATIONS; i++) begin
				if (sidx_s4 == SW'(i)) begin
					if (vert_s4 && (!seen_v[i] || mag_s4 < min_v[i]))
						min_v[i] <= mag_s4;
					if (!vert_s4 && (!seen_h[i] || mag_s4 < min_h[i]))
						min_h[i] <= mag_s4;
				end
			end
		end
	end

	// divider operands
	assign sel     = cmd.sel_idx[SW-1:0];
	assign min_sel = cmd.sel_h ? min_h[sel] : min_v[sel];

	always_comb begin
		case (cmd.div_src)
			DS_AVG_V: begin
				div_num = ND'(sum_v_q) + ND'(cnt_v_q >> 1);
				div_den = DD'(cnt_v_q);
			end
			DS_AVG_H: begin
				div_num = ND'(sum_h_q) + ND'(cnt_h_q >> 1);
				div_den = DD'(cnt_h_q);
			end
			default: begin
				div_num = ND'(min_sel) + ND'(den >> 1);
				div_den = den;
			end
		endcase
	end

	thdc_div #(.ND(ND), .DD(DD)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_q)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_go)
			src_q <= cmd.div_src;
		if (cmd.trk_start) begin
			sum_v_q <= '0;
			sum_h_q <= '0;
			cnt_v_q <= '0;
			cnt_h_q <= '0;
		end else if (div_done) begin
			case (src_q)
				DS_AVG_V: av_q <= div_q;
				DS_AVG_H: ah_q <= div_q;
				default: begin
					if (cmd.sel_h) begin
						sum_h_q <= sum_h_q + SUMW'(div_q);
						cnt_h_q <= cnt_h_q + CNW'(1);
					end else begin
						sum_v_q <= sum_v_q + SUMW'(div_q);
						cnt_v_q <= cnt_v_q + CNW'(1);
					end
				end
			endcase
		end
	end

	// result register
	always_comb begin
		if (overflow_q)
			st_code = ST_OVERFLOW;
		else if (failed_q)
			st_code = ST_NO_PLANE;
		else if (!tracks_q)
			st_code = ST_NO_TRACK;
		else
			st_code = ST_SCORED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.end_evt)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.end_evt) begin
			res_q.status      <= st_code;
			res_q.event_score <= (st_code == ST_SCORED) ? run_q : '0;
			case (st_code)
				ST_SCORED:   res_q.passed <= run_q <= thresh_q;
				ST_NO_TRACK: res_q.passed <= !mode_q;
				default:     res_q.passed <= 1'b0;
			endcase
		end
	end

	assign hit_count     = hit_cnt_q;
	assign result_valid  = res_valid_q;
	assign result        = res_q;
	assign sts.event_failed = failed_q;
	assign sts.pipe_busy = valid_s1 | valid_s2 | valid_s3 | valid_s4;
	assign sts.div_done  = div_done;
	assign sts.seen_sel  = cmd.sel_h ? seen_h[sel] : seen_v[sel];
	assign sts.no_plane  = (cnt_v_q == '0) || (cnt_h_q == '0);
	assign sts.res_pend  = res_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hit_cnt_q <= CW'(MAX_HITS))
		else $error("hit count beyond store depth");

	a_div_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !valid_s4)
		else $error("division overlaps distance pipeline");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.end_evt |=> (hit_cnt_q == '0) && res_valid_q && !tracks_q)
		else $error("end of event did not clear and post a result");

endmodule

>>> rtl/thdc_ctrl.sv
// ----------------------------------------------------------------------------
// thdc_ctrl
// Sequencer: accepts items, walks the hit store, runs divisions and merge.
// ----------------------------------------------------------------------------
module thdc_ctrl import thdc_pkg::*; #(
	parameter int MAX_HITS     = MAX_HITS_DEF,
	parameter int NUM_STATIONS = NUM_STN_DEF,
	parameter int AW           = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1,
	parameter int CW           = $clog2(MAX_HITS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  op_t           op,
	input  logic          result_stall,
	input  logic [CW-1:0] hit_count,
	input  sts_t          sts,
	output logic          item_stall,
	output cmd_t          cmd,
	output logic [AW-1:0] rd_addr
);

	state_t           state_q, state_d;
	logic [CW-1:0]    idx_q, idx_d;
	logic [STN_W-1:0] sidx_q, sidx_d;
	logic             h_q, h_d;
	logic             accept;

	assign item_stall = (state_q != S_IDLE) || (op == OP_END && sts.res_pend && result_stall);
	assign accept     = item_valid && !item_stall;
	assign rd_addr    = idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			sidx_q  <= '0;
			h_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			sidx_q  <= sidx_d;
			h_q     <= h_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		sidx_d  = sidx_q;
		h_d     = h_q;
		cmd     = '0;
		cmd.div_src = DS_STATION;
		cmd.sel_h   = h_q;
		cmd.sel_idx = sidx_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_LOAD:  cmd.hit_wr = 1'b1;
						OP_END:   cmd.end_evt = 1'b1;
						OP_TRACK: begin
							if (!sts.event_failed) begin
								cmd.trk_start = 1'b1;
								idx_d   = '0;
								state_d = S_WALK;
							end
						end
						default: ;
					endcase
				end
			end
			S_WALK: begin
				if (idx_q == hit_count) begin
					state_d = S_DRAIN;
				end else begin
					cmd.rd_en = 1'b1;
					idx_d     = idx_q + CW'(1);
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					sidx_d  = '0;
					h_d     = 1'b0;
					state_d = S_DSEL;
				end
			end
			S_DSEL, S_DWAIT: begin
				if (state_q == S_DSEL && sts.seen_sel) begin
					cmd.div_go = 1'b1;
					state_d    = S_DWAIT;
				end else if (state_q == S_DSEL || sts.div_done) begin
					state_d = S_DSEL;
					if (sidx_q == STN_W'(NUM_STATIONS - 1)) begin
						sidx_d = '0;
						h_d    = 1'b1;
						if (h_q)
							state_d = S_AVGV;
					end else begin
						sidx_d = sidx_q + STN_W'(1);
					end
				end
			end
			S_AVGV: begin
				if (sts.no_plane) begin
					cmd.set_fail = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.div_go  = 1'b1;
					cmd.div_src = DS_AVG_V;
					state_d     = S_AVGVW;
				end
			end
			S_AVGVW: begin
				if (sts.div_done) begin
					cmd.div_go  = 1'b1;
					cmd.div_src = DS_AVG_H;
					state_d     = S_AVGHW;
				end
			end
			S_AVGHW: begin
				if (sts.div_done)
					state_d = S_MERGE;
			end
			S_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> item_stall)
		else $error("item taken while sequencer busy");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (state_q == S_WALK) && (idx_q < hit_count))
		else $error("hit store read outside walk");

	a_track_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trk_start |=> (state_q == S_WALK) && (idx_q == '0))
		else $error("track did not start a walk");

endmodule

>>> bench/track_hit_doca_cut_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_hit_doca_cut_tb
// Self-checking bench for the track to hit distance cut.
// ----------------------------------------------------------------------------
// A short table of directed beats is followed by random events: hits, tracks
// and end-of-event beats with noise mixed in. The events run under several
// threshold and mode settings. Every accepted beat advances a local model of
// the cut. Each result beat is checked against the oldest expected verdict.
// ----------------------------------------------------------------------------
module track_hit_doca_cut_tb import thdc_pkg::*;;

	localparam int HITS  = 256;
	localparam int STNS  = 5;
	localparam int DRAIN = 700;
	localparam int IW    = $bits(item_t);

	typedef struct {
		logic       vert;
		logic [2:0] stn;
		longint     z;
		longint     t;
	} hit_rec_t;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t verdict;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	item_t                 item = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = CFG_THRESH;
	logic [SCORE_BITS-1:0] cfg_data = '0;

	// local model of the cut
	hit_rec_t              hits[HITS];
	int                    n_hits;
	logic [SCORE_BITS-1:0] min_v[STNS], min_h[STNS];
	bit                    seen_v[STNS], seen_h[STNS];
	logic [SCORE_BITS-1:0] run_score;
	bit                    trk_seen, ev_failed, ovf;
	logic [SCORE_BITS-1:0] thr;
	bit                    all_mode;

	result_t expected_verdicts[$];
	int      n_errors;
	int      n_sent;
	bit      calm_tx, calm_rx;
	int      rx_hold;
	row_t    plan[$];

	track_hit_doca_cut dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		#60_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [SCORE_BITS-1:0] doca(longint s_t, longint d_t, longint s_z,
		longint d_z, longint h_z, longint h_t);
		longint num, den, q;
		if (d_z == 0)
			return SCORE_MAX;
		num = (s_t - h_t) * d_z + d_t * (h_z - s_z);
		if (num < 0)
			num = -num;
		den = (d_z < 0) ? -d_z : d_z;
		if (num / den >= longint'(SCORE_MAX))
			return SCORE_MAX;
		q = (num + den / 2) / den;
		if (q > longint'(SCORE_MAX))
			return SCORE_MAX;
		return q[SCORE_BITS-1:0];
	endfunction

	function automatic void clear_event();
		n_hits = 0;
		run_score = '0;
		trk_seen = 0;
		ev_failed = 0;
		ovf = 0;
	endfunction

	function automatic void score_track(item_t it);
		longint sx, sy, sz, dx, dy, dz, sum_v, sum_h;
		int nv, nh, s;
		logic [SCORE_BITS-1:0] d, av, ah, trk;
		sx = longint'(it.coord_0);
		sy = longint'(it.coord_1);
		sz = longint'(it.coord_2);
		dx = longint'(it.coord_3) - sx;
		dy = longint'(it.coord_4) - sy;
		dz = longint'(it.coord_5) - sz;
		if (ev_failed)
			return;
		for (int i = 0; i < STNS; i++) begin
			min_v[i] = SCORE_MAX;
			min_h[i] = SCORE_MAX;
			seen_v[i] = 0;
			seen_h[i] = 0;
		end
		for (int i = 0; i < n_hits; i++) begin
			s = hits[i].stn - 1;
			if (hits[i].vert) begin
				d = doca(sx, dx, sz, dz, hits[i].z, hits[i].t);
				if (!seen_v[s] || d < min_v[s])
					min_v[s] = d;
				seen_v[s] = 1;
			end else begin
				d = doca(sy, dy, sz, dz, hits[i].z, hits[i].t);
				if (!seen_h[s] || d < min_h[s])
					min_h[s] = d;
				seen_h[s] = 1;
			end
		end
		sum_v = 0; sum_h = 0; nv = 0; nh = 0;
		for (int i = 0; i < STNS; i++) begin
			if (seen_v[i]) begin
				sum_v += min_v[i];
				nv++;
			end
			if (seen_h[i]) begin
				sum_h += min_h[i];
				nh++;
			end
		end
		if (nv == 0 || nh == 0) begin
			ev_failed = 1;
			return;
		end
		av = SCORE_BITS'((sum_v + nv / 2) / nv);
		ah = SCORE_BITS'((sum_h + nh / 2) / nh);
		trk = (av > ah) ? av : ah;
		if (!trk_seen || (all_mode ? trk > run_score : trk < run_score))
			run_score = trk;
		trk_seen = 1;
	endfunction

	// returns 1 when the beat produces a verdict
	function automatic bit advance_model(item_t it, output result_t r);
		r = '0;
		case (it.op)
			OP_LOAD: begin
				if (it.hit_usable && it.hit_station >= 1 && it.hit_station <= STNS) begin
					if (n_hits >= HITS)
						ovf = 1;
					else begin
						hits[n_hits].vert = it.hit_vertical;
						hits[n_hits].stn = it.hit_station;
						hits[n_hits].z = (longint'(it.coord_0) + longint'(it.coord_1)) >>> 1;
						hits[n_hits].t = (longint'(it.coord_2) + longint'(it.coord_3)) >>> 1;
						n_hits++;
					end
				end
			end
			OP_TRACK: score_track(it);
			OP_END: begin
				if (ovf)
					r.status = ST_OVERFLOW;
				else if (ev_failed)
					r.status = ST_NO_PLANE;
				else if (!trk_seen) begin
					r.status = ST_NO_TRACK;
					r.passed = !all_mode;
				end else begin
					r.status = ST_SCORED;
					r.event_score = run_score;
					r.passed = run_score <= thr;
				end
				clear_event();
				return 1;
			end
			default: ;
		endcase
		return 0;
	endfunction

	task automatic push_item(item_t it, bit typed = 0, result_t verdict = '0);
		int gap;
		result_t r;
		gap = calm_tx ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(item_valid && !item_stall));
		n_sent++;
		if (advance_model(it, r))
			expected_verdicts = {expected_verdicts, (typed ? verdict : r)};
	endtask

	task automatic write_reg(logic idx, logic [SCORE_BITS-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_THRESH)
			thr = data;
		else
			all_mode = data[0];
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic row_t row(op_t op, logic v, logic [2:0] s, logic u, int c0, int c1,
		int c2, int c3, int c4, int c5, bit typed = 0, result_t verdict = '0);
		row_t x;
		x.it = '{op, v, s, u, COORD_BITS'(c0), COORD_BITS'(c1), COORD_BITS'(c2),
			COORD_BITS'(c3), COORD_BITS'(c4), COORD_BITS'(c5)};
		x.typed = typed;
		x.verdict = verdict;
		return x;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rand_coord(int span);
		if (span == 0)
			return COORD_BITS'($urandom);
		return COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic item_t make_hit(int span);
		item_t it;
		it = IW'({$urandom, $urandom, $urandom, $urandom, $urandom});
		it.op = OP_LOAD;
		it.hit_station = STN_W'($urandom_range(1, STNS));
		it.hit_usable = 1'b1;
		it.coord_0 = rand_coord(span);
		it.coord_1 = rand_coord(span);
		it.coord_2 = rand_coord(span);
		it.coord_3 = rand_coord(span);
		return it;
	endfunction

	function automatic item_t make_track(int span);
		item_t it;
		it = IW'({$urandom, $urandom, $urandom, $urandom, $urandom});
		it.op = OP_TRACK;
		it.coord_0 = rand_coord(span);
		it.coord_1 = rand_coord(span);
		it.coord_2 = rand_coord(span);
		it.coord_3 = rand_coord(span);
		it.coord_4 = rand_coord(span);
		it.coord_5 = ($urandom_range(0, 15) == 0) ? it.coord_2 : rand_coord(span);
		return it;
	endfunction

	function automatic item_t make_noise();
		item_t it;
		it = IW'({$urandom, $urandom, $urandom, $urandom, $urandom});
		case ($urandom_range(0, 2))
			0: it.op = OP_NONE;
			1: begin
				it.op = OP_LOAD;
				it.hit_usable = 1'b0;
			end
			default: begin
				it.op = OP_LOAD;
				it.hit_station = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(6, 7));
			end
		endcase
		return it;
	endfunction

	task automatic run_event(bit flood);
		int n_hit, n_trk, span;
		item_t it;
		case ($urandom_range(0, 9))
			0: span = 0;
			1, 2: span = 50000;
			3, 4, 5: span = 100;
			default: span = 2000;
		endcase
		calm_tx = ($urandom_range(0, 7) == 0);
		calm_rx = ($urandom_range(0, 7) == 0);
		n_hit = flood ? HITS + 2
			: ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		n_trk = flood ? 1 : $urandom_range(0, 4);
		while (n_hit + n_trk > 0) begin
			if ($urandom_range(0, 9) == 0)
				push_item(make_noise());
			if ($urandom_range(1, n_hit + n_trk) <= n_trk) begin
				push_item(make_track(span));
				n_trk--;
			end else begin
				push_item(make_hit(span));
				n_hit--;
			end
		end
		it = IW'({$urandom, $urandom, $urandom, $urandom, $urandom});
		it.op = OP_END;
		push_item(it);
		if ($urandom_range(0, 9) == 0) begin
			item_valid <= 1'b0;
			while (expected_verdicts.size() != 0)
				@(posedge clk);
		end
	endtask

	// result side: stall for a random count after each beat
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			rx_hold = calm_rx ? 0 : $urandom_range(0, 6);
		else if (rx_hold > 0)
			rx_hold--;
		result_stall <= (rx_hold > 0);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected result beat: %p", result);
				n_errors++;
			end else begin
				want = expected_verdicts.pop_front();
				if (result.event_score !== want.event_score) begin
					$error("event_score: expected %0d, got %0d", want.event_score,
						result.event_score);
					n_errors++;
				end
				if (result.passed !== want.passed) begin
					$error("passed: expected %0d, got %0d", want.passed, result.passed);
					n_errors++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					n_errors++;
				end
			end
		end
	end

	initial begin
		logic [SCORE_BITS-1:0] thr_set[5];
		bit mode_set[5];
		int quota;
		rx_hold = 0;
		n_errors = 0;
		n_sent = 0;
		calm_tx = 0;
		calm_rx = 0;
		thr = SCORE_MAX;
		all_mode = 0;
		clear_event();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = {plan, row(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{'0, 1'b1, ST_NO_TRACK})};
		plan = {plan, row(OP_LOAD, 1, 1, 1, 8388607, -8388608, 8388607, -8388608, 0, 0)};
		plan = {plan, row(OP_LOAD, 0, 5, 1, -8388608, -8388608, -8388608, -8388608, 0, 0)};
		plan = {plan, row(OP_LOAD, 1, 3, 0, 10, 20, 30, 40, 0, 0)};
		plan = {plan, row(OP_LOAD, 0, 0, 1, 10, 20, 30, 40, 0, 0)};
		plan = {plan, row(OP_LOAD, 1, 6, 1, 10, 20, 30, 40, 0, 0)};
		plan = {plan, row(OP_LOAD, 0, 7, 1, 10, 20, 30, 40, 0, 0)};
		plan = {plan, row(OP_NONE, 1, 7, 1, -1, -1, -1, -1, -1, -1)};
		plan = {plan, row(OP_TRACK, 0, 0, 0, 0, 0, -8388608, 100, 100, 8388607)};
		plan = {plan, row(OP_TRACK, 0, 0, 0, 5, 5, 1000, 7, 7, 1000)};
		plan = {plan, row(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
		plan = {plan, row(OP_LOAD, 1, 2, 1, 100, 200, 5, 6, 0, 0)};
		plan = {plan, row(OP_TRACK, 0, 0, 0, 0, 0, 0, 10, 10, 1000)};
		plan = {plan, row(OP_TRACK, 0, 0, 0, 1, 1, 1, 2, 2, 2)};
		plan = {plan, row(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{'0, 1'b0, ST_NO_PLANE})};
		plan = {plan, row(OP_LOAD, 1, 4, 1, 1000, 2000, 50, 60, 0, 0)};
		plan = {plan, row(OP_LOAD, 0, 4, 1, 1000, 2000, -30, -40, 0, 0)};
		plan = {plan, row(OP_TRACK, 0, 0, 0, 0, 0, 0, 100, -100, 3000)};
		plan = {plan, row(OP_TRACK, 0, 0, 0, -8388608, 8388607, -8388608,
			8388607, -8388608, -8388607)};
		plan = {plan, row(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
		plan = {plan, row(OP_TRACK, 0, 0, 0, 0, 0, 0, 1, 1, 1)};
		plan = {plan, row(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{'0, 1'b0, ST_NO_PLANE})};
		foreach (plan[i])
			push_item(plan[i].it, plan[i].typed, plan[i].verdict);

		thr_set[0] = SCORE_MAX;        mode_set[0] = 1;
		thr_set[1] = '0;               mode_set[1] = 1;
		thr_set[2] = SCORE_BITS'($urandom_range(0, 3000)); mode_set[2] = 0;
		thr_set[3] = SCORE_BITS'($urandom_range(0, 3000)); mode_set[3] = 1;
		thr_set[4] = 1;                mode_set[4] = 0;
		for (int p = 0; p < 5; p++) begin
			wait_drained();
			write_reg(CFG_THRESH, thr_set[p]);
			write_reg(CFG_MODE, SCORE_BITS'(mode_set[p]));
			quota = n_sent + 345;
			if (p == 1 || p == 3)
				run_event(1);
			while (n_sent < quota)
				run_event(0);
		end

		wait_drained();
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
